@@ design/mks_pkg.sv @@
package mks_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NUL   = 2'd3;

    localparam logic [0:0] CFG_DEBOUNCE_COUNT = 1'd0;
    localparam logic [0:0] CFG_FN_KEY_BIT     = 1'd1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd100;
    localparam logic [3:0]  FN_BIT_RESET   = 4'd1;

    typedef struct packed {
        logic       any_down;
        logic       fn_held;
        logic       key_ready;
        logic [7:0] key_char;
        logic [1:0] row_drive;
    } result_t;

    typedef struct packed {
        logic [15:0] debounce_count;
        logic [3:0]  fn_key_bit;
    } cfg_t;

    // Plain keys in the lower half, Fn layer in the upper half.
    localparam logic [7:0] CHAR_TABLE [32] = '{
        8'h0A, 8'h4D, 8'h30, 8'h2C,
        8'h5F, 8'h37, 8'h38, 8'h39,
        8'h3C, 8'h34, 8'h35, 8'h36,
        8'h3E, 8'h31, 8'h32, 8'h33,
        8'h70, 8'h6D, 8'h6E, 8'h6F,
        8'h6C, 8'h69, 8'h6A, 8'h6B,
        8'h68, 8'h65, 8'h66, 8'h67,
        8'h62, 8'h61, 8'h62, 8'h63
    };

endpackage

@@ design/mks_core.sv @@
module mks_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_accept,
    input  logic [1:0]      func,
    input  logic [3:0]      sense_pins,
    input  mks_pkg::cfg_t   cfg,
    output mks_pkg::result_t result
);

    logic [1:0]  row_reg, row_next;
    logic [15:0] map_reg, map_next;
    logic [15:0] prev_reg, prev_next;
    logic [15:0] stable_reg, stable_next;
    logic        present_reg, present_next;
    logic        pressed_reg, pressed_next;
    logic        fn_reg, fn_next;
    logic        ready_reg, ready_next;
    logic [7:0]  char_reg, char_next;

    logic [3:0]  nib;
    logic [15:0] tick_map;
    logic [1:0]  tick_row;
    logic        tick_present;
    logic [15:0] fn_mask;
    logic [15:0] masked_map;
    logic [15:0] stable_inc;
    logic [3:0]  sel_nib;
    logic [1:0]  sel_row;
    logic [1:0]  sel_col;
    logic        sel_onehot;
    logic        key_fn;

    always_comb begin
        nib      = ~sense_pins;
        tick_map = map_reg;
        unique case (row_reg)
            2'd0: tick_map[3:0]   = nib;
            2'd1: tick_map[7:4]   = nib;
            2'd2: tick_map[11:8]  = nib;
            2'd3: tick_map[15:12] = nib;
        endcase
        tick_row     = row_reg + 2'd1;
        tick_present = present_reg || (tick_row == 2'd0 && tick_map != 16'd0);
        fn_mask      = 16'd1 << cfg.fn_key_bit;
        masked_map   = tick_map & ~fn_mask;
        key_fn       = (tick_map & fn_mask) != 16'd0;
        stable_inc   = stable_reg + 16'd1;
    end

    always_comb begin
        sel_row = 2'd3;
        sel_nib = masked_map[15:12];
        priority if (masked_map[3:0] != 4'd0) begin
            sel_row = 2'd0;
            sel_nib = masked_map[3:0];
        end else if (masked_map[7:4] != 4'd0) begin
            sel_row = 2'd1;
            sel_nib = masked_map[7:4];
        end else if (masked_map[11:8] != 4'd0) begin
            sel_row = 2'd2;
            sel_nib = masked_map[11:8];
        end
        sel_onehot = 1'b1;
        sel_col    = 2'd0;
        unique case (sel_nib)
            4'b0001: sel_col = 2'd0;
            4'b0010: sel_col = 2'd1;
            4'b0100: sel_col = 2'd2;
            4'b1000: sel_col = 2'd3;
            default: sel_onehot = 1'b0;
        endcase
    end

    always_comb begin
        row_next     = row_reg;
        map_next     = map_reg;
        prev_next    = prev_reg;
        stable_next  = stable_reg;
        present_next = present_reg;
        pressed_next = pressed_reg;
        fn_next      = fn_reg;
        ready_next   = ready_reg;
        char_next    = char_reg;
        unique case (func)
            mks_pkg::FUNC_TICK: begin
                row_next     = tick_row;
                map_next     = tick_map;
                prev_next    = tick_map;
                present_next = tick_present;
                if (!pressed_reg && tick_present) begin
                    if (prev_reg == tick_map) begin
                        stable_next = stable_inc;
                        if (stable_inc == cfg.debounce_count) begin
                            if (masked_map != 16'd0) begin
                                pressed_next = 1'b1;
                                fn_next      = key_fn;
                                if (sel_onehot) begin
                                    char_next  = mks_pkg::CHAR_TABLE[{key_fn, sel_row, sel_col}];
                                    ready_next = 1'b1;
                                end
                            end else begin
                                stable_next = 16'd0;
                            end
                        end
                    end else begin
                        pressed_next = 1'b0;
                        present_next = 1'b0;
                        stable_next  = 16'd0;
                    end
                end
            end
            mks_pkg::FUNC_READ, mks_pkg::FUNC_CLEAR: begin
                ready_next   = 1'b0;
                pressed_next = 1'b0;
                present_next = 1'b0;
            end
            mks_pkg::FUNC_NUL: begin
                char_next = 8'd0;
            end
        endcase
    end

    always_comb begin
        result.row_drive = row_next;
        result.key_char  = char_reg;
        result.key_ready = ready_next;
        result.fn_held   = fn_next;
        result.any_down  = map_next != 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= 2'd0;
            map_reg     <= 16'd0;
            prev_reg    <= 16'd0;
            stable_reg  <= 16'd0;
            present_reg <= 1'b0;
            pressed_reg <= 1'b0;
            fn_reg      <= 1'b0;
            ready_reg   <= 1'b0;
            char_reg    <= 8'd0;
        end else if (item_accept) begin
            row_reg     <= row_next;
            map_reg     <= map_next;
            prev_reg    <= prev_next;
            stable_reg  <= stable_next;
            present_reg <= present_next;
            pressed_reg <= pressed_next;
            fn_reg      <= fn_next;
            ready_reg   <= ready_next;
            char_reg    <= char_next;
        end
    end

endmodule

@@ design/matrix_keypad_scanner.sv @@
// One item per cycle while s_axis_tready is high; each accepted item updates the scan,
// debounce and lookup state, and its result is registered in the output or second entry.
// A two-entry output stage keeps s_axis_tready high while one result waits for m_axis_tready.
// Reset: aresetn is synchronous and active low; it clears all scan state and both result
// entries, and sets debounce_count to 100 and fn_key_bit to 1.
module matrix_keypad_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] sense_pins, [7:4] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] row_drive, [9:2] key_char, [10] key_ready,
                                        // [11] fn_held, [12] any_down, [15:13] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    mks_pkg::cfg_t    cfg_reg;
    mks_pkg::result_t result;
    mks_pkg::result_t out_data_reg;
    mks_pkg::result_t skid_data_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             item_accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign item_accept   = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_count <= mks_pkg::DEBOUNCE_RESET;
            cfg_reg.fn_key_bit     <= mks_pkg::FN_BIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mks_pkg::CFG_DEBOUNCE_COUNT: cfg_reg.debounce_count <= cfg_data;
                mks_pkg::CFG_FN_KEY_BIT:     cfg_reg.fn_key_bit     <= cfg_data[3:0];
            endcase
        end
    end

    mks_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .func        (s_axis_tuser),
        .sense_pins  (s_axis_tdata[3:0]),
        .cfg         (cfg_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_axis_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= item_accept;
            end
        end else if (item_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_axis_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (item_accept) begin
                out_data_reg <= result;
            end
        end else if (item_accept) begin
            skid_data_reg <= result;
        end
    end

endmodule
